FILE: design/imdu_pkg.sv
// ----------------------------------------------------------------------------
// imdu_pkg
// shared types and codes of the integer multiply/divide unit
// ----------------------------------------------------------------------------
package imdu_pkg;

  localparam int ACTION_W = 3;

  // operation codes
  typedef enum logic [ACTION_W-1:0] {
    ACT_MUL  = 3'd0,
    ACT_DIVU = 3'd1,
    ACT_DIVS = 3'd2,
    ACT_REMU = 3'd3,
    ACT_REMS = 3'd4
  } action_t;

  // sequencer states, one-hot
  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_PREPA = 5'b00010,
    ST_PREPB = 5'b00100,
    ST_RUN   = 5'b01000,
    ST_FIX   = 5'b10000
  } state_t;

endpackage

FILE: design/int32_mul_div_unit.sv
// ----------------------------------------------------------------------------
// int32_mul_div_unit
// iterative multiply / divide / remainder unit on one shared adder
// ----------------------------------------------------------------------------
//
// channel  | ports                                          | handshake
// ---------+------------------------------------------------+--------------------------
// input    | in_action, in_first_operand, in_second_operand | start && !busy
// result   | out_result_word                                | out_valid, one cycle
//
// - multiply runs the loop in ST_RUN and then ST_FIX; divides and remainders
//   first pass ST_PREPA and ST_PREPB for operand sign fix-up
// - a radix-2 shift-add / shift-subtract loop does one operand bit per cycle
//   through a single adder/subtractor, which also does every negation
// - out_valid rises in the cycle after the final cycle; busy is low in that cycle,
//   so the next transaction may be accepted while the result is shown
// - unused action codes go straight to the fix-up state and give 0
// - rst_n is synchronous and active low; it clears the sequencer and out_valid
// - the receiver cannot stall: a result is shown for exactly one cycle
//
module int32_mul_div_unit
  import imdu_pkg::*;
#(
  parameter int DATA_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [ACTION_W-1:0]   in_action,
  input  logic [DATA_WIDTH-1:0] in_first_operand,
  input  logic [DATA_WIDTH-1:0] in_second_operand,
  output logic                  out_valid,
  output logic [DATA_WIDTH-1:0] out_result_word
);

  localparam int W     = DATA_WIDTH;
  localparam int CNT_W = $clog2(W);

  // sequencer and working registers
  state_t          state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  action_t         act_r, act_nxt;
  logic            valid_act_r, valid_act_nxt;  // action code is a real operation
  logic            sa_r, sa_nxt;                // sign of first operand
  logic            sb_r, sb_nxt;                // sign of second operand
  logic            dz_r, dz_nxt;                // divisor is zero
  logic [W-1:0]    acc_r, acc_nxt;              // product / partial remainder
  logic [W-1:0]    quo_r, quo_nxt;              // multiplier / dividend -> quotient
  logic [W-1:0]    opb_r, opb_nxt;              // multiplicand / divisor
  logic            out_valid_r, out_valid_nxt;
  logic [W-1:0]    out_word_r, out_word_nxt;

  // shared adder/subtractor
  logic [W:0]      add_x, add_y;
  logic            add_sub;
  logic [W+1:0]    add_sum;
  logic            add_carry;

  assign add_sum   = {1'b0, add_x} + {1'b0, (add_sub ? ~add_y : add_y)}
                   + {{(W+1){1'b0}}, add_sub};
  assign add_carry = add_sum[W+1];

  // decode of the held action
  logic signed_op, is_quot, is_mul, neg_res;
  logic [W-1:0] fix_val;

  always_comb begin
    signed_op = (act_r == ACT_DIVS) || (act_r == ACT_REMS);
    is_quot   = (act_r == ACT_DIVU) || (act_r == ACT_DIVS);
    is_mul    = (act_r == ACT_MUL);
    // quotient sign from both operands, remainder sign follows dividend
    neg_res   = valid_act_r && signed_op && (is_quot ? (sa_r ^ sb_r) : sa_r);
    if (!valid_act_r) begin
      fix_val = '0;
    end else if (is_mul) begin
      fix_val = acc_r;
    end else if (is_quot) begin
      fix_val = dz_r ? '0 : quo_r;
    end else begin
      fix_val = acc_r;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    act_nxt       = act_r;
    valid_act_nxt = valid_act_r;
    sa_nxt        = sa_r;
    sb_nxt        = sb_r;
    dz_nxt        = dz_r;
    acc_nxt       = acc_r;
    quo_nxt       = quo_r;
    opb_nxt       = opb_r;
    out_valid_nxt = 1'b0;
    out_word_nxt  = out_word_r;
    add_x         = '0;
    add_y         = '0;
    add_sub       = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          act_nxt       = action_t'(in_action);
          valid_act_nxt = (in_action <= ACT_REMS);
          sa_nxt        = in_first_operand[W-1];
          sb_nxt        = in_second_operand[W-1];
          dz_nxt        = (in_second_operand == '0);
          acc_nxt       = '0;
          cnt_nxt       = CNT_W'(W - 1);
          if (in_action == ACT_MUL) begin
            // multiplier bits go out of quo_r lsb first
            quo_nxt   = in_second_operand;
            opb_nxt   = in_first_operand;
            state_nxt = ST_RUN;
          end else if (in_action <= ACT_REMS) begin
            quo_nxt   = in_first_operand;
            opb_nxt   = in_second_operand;
            state_nxt = ST_PREPA;
          end else begin
            state_nxt = ST_FIX;
          end
        end
      end

      ST_PREPA: begin
        // dividend magnitude
        add_x   = '0;
        add_y   = {1'b0, quo_r};
        add_sub = 1'b1;
        if (signed_op && sa_r) begin
          quo_nxt = add_sum[W-1:0];
        end
        state_nxt = ST_PREPB;
      end

      ST_PREPB: begin
        // divisor magnitude
        add_x   = '0;
        add_y   = {1'b0, opb_r};
        add_sub = 1'b1;
        if (signed_op && sb_r) begin
          opb_nxt = add_sum[W-1:0];
        end
        state_nxt = ST_RUN;
      end

      ST_RUN: begin
        if (is_mul) begin
          // shift-add: accumulate shifted multiplicand on each set bit
          add_x   = {1'b0, acc_r};
          add_y   = {1'b0, opb_r};
          add_sub = 1'b0;
          if (quo_r[0]) begin
            acc_nxt = add_sum[W-1:0];
          end
          opb_nxt = {opb_r[W-2:0], 1'b0};
          quo_nxt = {1'b0, quo_r[W-1:1]};
        end else begin
          // restoring shift-subtract, one quotient bit per cycle
          add_x   = {acc_r, quo_r[W-1]};
          add_y   = {1'b0, opb_r};
          add_sub = 1'b1;
          acc_nxt = add_carry ? add_sum[W-1:0] : add_x[W-1:0];
          quo_nxt = {quo_r[W-2:0], add_carry};
        end
        if (cnt_r == '0) begin
          state_nxt = ST_FIX;
        end else begin
          cnt_nxt = cnt_r - CNT_W'(1);
        end
      end

      ST_FIX: begin
        // result select and sign correction
        add_x         = '0;
        add_y         = {1'b0, fix_val};
        add_sub       = neg_res;
        out_word_nxt  = add_sum[W-1:0];
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    cnt_r       <= cnt_nxt;
    act_r       <= act_nxt;
    valid_act_r <= valid_act_nxt;
    sa_r        <= sa_nxt;
    sb_r        <= sb_nxt;
    dz_r        <= dz_nxt;
    acc_r       <= acc_nxt;
    quo_r       <= quo_nxt;
    opb_r       <= opb_nxt;
    out_word_r  <= out_word_nxt;
  end

  assign busy            = (state_r != ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_result_word = out_word_r;

endmodule
